// ===== sv/sonar_median_change_filter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Sonar median change filter assertion macros
// Concurrent assertion shorthands on clock and reset for the filter modules.
// ----------------------------------------------------------------------------
`ifndef SONAR_MEDIAN_CHANGE_FILTER_TOP_MACROS_SVH
`define SONAR_MEDIAN_CHANGE_FILTER_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define SMCF_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SMCF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== sv/smcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sonar median change filter package
// Field widths, register indexes, reset values and divider handshake types.
// ----------------------------------------------------------------------------
package smcf_pkg;

   localparam int ECHO_W  = 16;
   localparam int SERVO_W = 16;
   localparam int ANGLE_W = 8;
   localparam int DIST_W  = 10;
   localparam int USEC_W  = 8;
   localparam int STEP_W  = 8;
   localparam int TOL_W   = 10;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DIV_N_W   = 16;
   localparam int DIV_D_W   = 8;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   localparam logic [CSR_IDX_W-1:0] CSR_USEC_PER_CM        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE_CM    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_CENTER       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_STEP         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_TOLERANCE = 3'd4;

   localparam logic [USEC_W-1:0]  RST_USEC_PER_CM        = 8'd58;
   localparam logic [DIST_W-1:0]  RST_MAX_DISTANCE_CM    = 10'd400;
   localparam logic [SERVO_W-1:0] RST_SERVO_CENTER       = 16'd1500;
   localparam logic [STEP_W-1:0]  RST_SERVO_STEP         = 8'd10;
   localparam logic [TOL_W-1:0]   RST_DISTANCE_TOLERANCE = 10'd2;

   localparam logic [ANGLE_W-1:0] ANGLE_POS_MAX = 8'h7F;
   localparam logic [ANGLE_W-1:0] ANGLE_NEG_MIN = 8'h80;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/smcf_div.sv =====
// ----------------------------------------------------------------------------
// Sonar median change filter divider
// Restoring unsigned divider, one quotient bit per cycle, nonzero divisor.
// ----------------------------------------------------------------------------
module smcf_div import smcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   div_ff, div_in;
   logic [DIV_D_W:0]     trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = div_req.dividend;
         div_in   = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? DIV_D_W'(trial - {1'b0, div_ff}) : trial[DIV_D_W-1:0];
         quo_in   = {quo_ff[DIV_N_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== sv/smcf_rank.sv =====
// ----------------------------------------------------------------------------
// Sonar median change filter ranker
// Visit one candidate slot a cycle and rank it against the whole window.
// ----------------------------------------------------------------------------
module smcf_rank import smcf_pkg::*; #(
   parameter int WINDOW = 5,
   parameter int SLOT_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIST_W-1:0] ring_dist [WINDOW],
   output logic              done,
   output logic [SLOT_W-1:0] slot
);

   localparam logic [SLOT_W-1:0] TARGET = SLOT_W'((WINDOW - 1) / 2);
   localparam logic [SLOT_W-1:0] LAST   = SLOT_W'(WINDOW - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [SLOT_W-1:0] cand_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] rank;
   logic [DIST_W-1:0] cand_dist;

   assign cand_dist = ring_dist[cand_ff];

   always_comb begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
         rank = rank + SLOT_W'((ring_dist[j] < cand_dist) ||
                               ((ring_dist[j] == cand_dist) && (SLOT_W'(j) < cand_ff)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cand_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cand_ff <= '0;
         end else if (busy_ff) begin
            if (rank == TARGET || cand_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               slot_ff <= (rank == TARGET) ? cand_ff : '0;
            end else begin
               cand_ff <= cand_ff + 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

// ===== sv/sonar_median_change_filter_top.sv =====
// ----------------------------------------------------------------------------
// Sonar median change filter
// Echo to distance and compare to angle through one shared divider, a ring of
// WINDOW samples, median pick and report on change.
//
//   channel  dir  beat payload (low bit first)
//   req_     in   echo_usec[15:0], servo_compare[31:16]
//   rsp_     out  angle_deg[7:0], distance_cm[17:8], zero pad
//   csr_     in   register index and data, one write per enabled cycle
//
// A nonzero echo passes through the divider twice, distance then angle, then the ranker
// once the ring is full and a decision step; a zero echo is taken and dropped.
// The serial divider sets most of the time that an item takes.
// req_tready is low while an item is at work; a waiting result holds rsp_.
// A report stalls in the decision state only while the previous one waits.
// Reset is synchronous; the ring holds no defined value until written.
// ----------------------------------------------------------------------------
`include "sonar_median_change_filter_top_macros.svh"

module sonar_median_change_filter_top import smcf_pkg::*; #(
   parameter int WINDOW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // echo_usec, servo_compare
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // angle_deg, distance_cm
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_wr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_ANG,
      ST_RANK,
      ST_DECIDE
   } state_type;

   state_type          state_ff;
   logic [USEC_W-1:0]  usec_per_cm_ff;
   logic [DIST_W-1:0]  max_distance_ff;
   logic [SERVO_W-1:0] servo_center_ff;
   logic [STEP_W-1:0]  servo_step_ff;
   logic [TOL_W-1:0]   tolerance_ff;

   logic [SERVO_W-1:0] servo_ff;
   logic               neg_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic [SLOT_W-1:0]  write_slot_ff;
   logic               ring_full_ff;
   logic [ANGLE_W-1:0] last_angle_ff;
   logic [DIST_W-1:0]  last_dist_ff;
   logic [ANGLE_W-1:0] med_angle_ff;
   logic [DIST_W-1:0]  med_dist_ff;
   logic               emit_ff;
   logic               rsp_valid_ff;
   logic [ANGLE_W-1:0] rsp_angle_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic [DIST_W-1:0]  ring_dist_ff  [WINDOW];
   logic [ANGLE_W-1:0] ring_angle_ff [WINDOW];

   div_req_type        div_req_ff;
   div_rsp_type        div_rsp;
   logic               rank_start_ff;
   logic               rank_done;
   logic [SLOT_W-1:0]  rank_slot;

   logic [ECHO_W-1:0]  req_echo;
   logic [SERVO_W-1:0] req_servo;
   logic [SERVO_W:0]   servo_diff;
   logic [DIV_N_W-1:0] servo_mag;
   logic [DIST_W-1:0]  dist_calc;
   logic [ANGLE_W-1:0] angle_calc;
   logic               ring_wr;
   logic [ANGLE_W-1:0] pick_angle;
   logic [DIST_W-1:0]  pick_dist;
   logic [DIST_W-1:0]  pick_delta;
   logic               pick_emit;

   assign req_echo  = req_tdata[ECHO_W-1:0];
   assign req_servo = req_tdata[ECHO_W+SERVO_W-1:ECHO_W];

   assign servo_diff = {1'b0, servo_ff} - {1'b0, servo_center_ff};
   assign servo_mag  = servo_diff[SERVO_W] ? DIV_N_W'(-servo_diff) : servo_diff[DIV_N_W-1:0];

   always_comb begin
      if (usec_per_cm_ff == '0) begin
         dist_calc = max_distance_ff;
      end else if (div_rsp.quotient > DIV_N_W'(max_distance_ff)) begin
         dist_calc = max_distance_ff;
      end else begin
         dist_calc = div_rsp.quotient[DIST_W-1:0];
      end
      if (neg_ff) begin
         angle_calc = (div_rsp.quotient > DIV_N_W'(128)) ? ANGLE_NEG_MIN
                    : ANGLE_W'(8'd0 - div_rsp.quotient[ANGLE_W-1:0]);
      end else begin
         angle_calc = (div_rsp.quotient > DIV_N_W'(127)) ? ANGLE_POS_MAX
                    : div_rsp.quotient[ANGLE_W-1:0];
      end
   end

   assign ring_wr = (state_ff == ST_ANG) && div_rsp.done;

   assign pick_angle = ring_angle_ff[rank_slot];
   assign pick_dist  = ring_dist_ff[rank_slot];
   assign pick_delta = (pick_dist > last_dist_ff) ? pick_dist - last_dist_ff
                                                 : last_dist_ff - pick_dist;
   assign pick_emit  = (pick_angle != last_angle_ff) || (pick_delta > tolerance_ff);

   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_dist_ff[write_slot_ff]  <= dist_ff;
         ring_angle_ff[write_slot_ff] <= angle_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         usec_per_cm_ff   <= RST_USEC_PER_CM;
         max_distance_ff  <= RST_MAX_DISTANCE_CM;
         servo_center_ff  <= RST_SERVO_CENTER;
         servo_step_ff    <= RST_SERVO_STEP;
         tolerance_ff     <= RST_DISTANCE_TOLERANCE;
         write_slot_ff    <= '0;
         ring_full_ff     <= 1'b0;
         last_angle_ff    <= '0;
         last_dist_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
         rank_start_ff    <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         rank_start_ff    <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_wr_index)
               CSR_USEC_PER_CM:        usec_per_cm_ff  <= csr_wr_data[USEC_W-1:0];
               CSR_MAX_DISTANCE_CM:    max_distance_ff <= csr_wr_data[DIST_W-1:0];
               CSR_SERVO_CENTER:       servo_center_ff <= csr_wr_data[SERVO_W-1:0];
               CSR_SERVO_STEP:         servo_step_ff   <= csr_wr_data[STEP_W-1:0];
               CSR_DISTANCE_TOLERANCE: tolerance_ff    <= csr_wr_data[TOL_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_echo != '0) begin
                  servo_ff            <= req_servo;
                  div_req_ff.start    <= 1'b1;
                  div_req_ff.dividend <= req_echo;
                  div_req_ff.divisor  <= (usec_per_cm_ff == '0) ? DIV_D_W'(1) : usec_per_cm_ff;
                  state_ff            <= ST_DIST;
               end
            end
            ST_DIST: begin
               if (div_rsp.done) begin
                  dist_ff             <= dist_calc;
                  neg_ff              <= servo_diff[SERVO_W];
                  div_req_ff.start    <= 1'b1;
                  div_req_ff.dividend <= servo_mag;
                  div_req_ff.divisor  <= (servo_step_ff == '0) ? DIV_D_W'(1) : servo_step_ff;
                  state_ff            <= ST_ANG;
               end
            end
            ST_ANG: begin
               if (div_rsp.done) begin
                  if (write_slot_ff == LAST_SLOT) begin
                     write_slot_ff <= '0;
                     ring_full_ff  <= 1'b1;
                     rank_start_ff <= 1'b1;
                     state_ff      <= ST_RANK;
                  end else begin
                     write_slot_ff <= write_slot_ff + 1'b1;
                     if (ring_full_ff) begin
                        rank_start_ff <= 1'b1;
                        state_ff      <= ST_RANK;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            ST_RANK: begin
               if (rank_done) begin
                  med_angle_ff <= pick_angle;
                  med_dist_ff  <= pick_dist;
                  emit_ff      <= pick_emit;
                  state_ff     <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!emit_ff) begin
                  state_ff <= ST_IDLE;
               end else if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_angle_ff  <= med_angle_ff;
                  rsp_dist_ff   <= med_dist_ff;
                  last_angle_ff <= med_angle_ff;
                  last_dist_ff  <= med_dist_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   smcf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   smcf_rank #(
      .WINDOW (WINDOW),
      .SLOT_W (SLOT_W)
   ) u_rank (
      .clock     (clock),
      .reset     (reset),
      .start     (rank_start_ff),
      .ring_dist (ring_dist_ff),
      .done      (rank_done),
      .slot      (rank_slot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_dist_ff, rsp_angle_ff};

   `SMCF_ASSERT_IMPLY(a_div_done_state, div_rsp.done, (state_ff == ST_DIST || state_ff == ST_ANG), "divider result outside a divide state")
   `SMCF_ASSERT_IMPLY(a_rank_done_state, rank_done, (state_ff == ST_RANK), "rank result outside rank state")
   `SMCF_ASSERT_IMPLY(a_last_matches_rsp, rsp_valid_ff, (last_angle_ff == rsp_angle_ff && last_dist_ff == rsp_dist_ff), "last report differs from pending beat")
   `SMCF_ASSERT(a_slot_in_range, (32'(write_slot_ff) < WINDOW), "write slot beyond window")

endmodule
